@@ sv/amf_pkg.sv @@
// Shared types, constants and helpers for the adaptive median filter.
package amf_pkg;

    localparam int unsigned MAX_WINDOW_DEF = 7;
    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned HEIGHT_CAP     = 2048;
    localparam int unsigned CFG_W          = 12;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [2:0]       MAX_WINDOW_RST   = 3'd7;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MAX_WINDOW   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] pixel;
        logic       first_of_frame;
    } t_in;

    typedef struct packed {
        logic [7:0] filtered_pixel;
        logic [2:0] window_used;
        logic       kept_original;
        logic       last_in_row;
        logic       last_in_frame;
    } t_out;

    typedef struct packed {
        logic [3:0] size;
        logic [7:0] centre;
        logic       last_in_row;
        logic       last_in_frame;
    } t_meta;

    typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_PUSH} t_fstate;
    typedef enum logic [1:0] {B_IDLE, B_SCAN, B_DONE} t_bstate;

    // Effective odd window size from the register value, capped at cap.
    function automatic logic [3:0] eff_size(input logic [2:0] mw, input logic [3:0] cap);
        logic [3:0] m;
        m = {1'b0, mw};
        if (!m[0] && m != 4'd0) m = m - 4'd1;
        if (m < 4'd3) m = 4'd3;
        if (m > cap) m = cap;
        return m;
    endfunction

endpackage

@@ sv/amf_queue.sv @@
// Small register queue between the front and the back.
module amf_queue #(
    parameter int unsigned DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [DW-1:0] i_data,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [DW-1:0] o_data
);
    import amf_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [DW-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wr <= (r_wr == PW'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (rd) r_rd <= (r_rd == PW'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            if (wr && !rd)      r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wr] <= i_data;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("front pushed into full queue");
endmodule

@@ sv/amf_front.sv @@
// Front: position tracking, line stores and window register; queues windows to filter.
module amf_front #(
    parameter int unsigned MAX_WINDOW = amf_pkg::MAX_WINDOW_DEF,
    parameter int unsigned MAX_WIDTH  = amf_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  amf_pkg::t_in                  i_item,
    input  logic [$clog2(MAX_WIDTH):0]    i_fw,
    input  logic [11:0]                   i_fh,
    input  logic [3:0]                    i_m,
    output logic                          o_q_push,
    input  logic                          i_q_full,
    output logic [(((MAX_WINDOW-1)/2)*2+1)**2*8-1:0] o_q_win,
    output amf_pkg::t_meta                o_q_meta
);
    import amf_pkg::*;

    localparam int unsigned WIN   = ((MAX_WINDOW - 1) / 2) * 2 + 1;
    localparam int unsigned CELLS = WIN * WIN;
    localparam int unsigned ROWS  = WIN - 1;
    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned SW    = (ROWS > 1) ? $clog2(ROWS) : 1;

    t_fstate r_state, n_state;
    logic [CW-1:0]  r_col;
    logic [10:0]    r_row;
    logic [SW-1:0]  r_slot, r_cur_slot;
    logic [7:0]     r_pix;
    logic           r_emit, r_lir, r_lif;
    logic [7:0]     r_win [CELLS];
    logic [ROWS*8-1:0] w_rd;
    logic [7:0]     w_col_in [WIN];

    logic           accept;
    logic [CW:0]    c0, nc;
    logic [11:0]    r0, nr;
    logic [SW-1:0]  s0, ns;
    logic           emit, lir, lif;

    assign o_full = (r_state != F_IDLE);
    assign accept = i_push && !o_full;

    // Place the pixel in the frame, then work out where the next one lands.
    always_comb begin
        c0 = i_item.first_of_frame ? '0 : {1'b0, r_col};
        r0 = i_item.first_of_frame ? '0 : {1'b0, r_row};
        s0 = i_item.first_of_frame ? '0 : r_slot;
        if (c0 >= i_fw) begin
            c0 = '0;
            r0 = r0 + 12'd1;
            s0 = (s0 == SW'(ROWS-1)) ? '0 : s0 + 1'b1;
        end
        if (r0 >= i_fh) begin
            r0 = '0;
            s0 = '0;
        end
        emit = (32'(r0) + 32'd1 >= 32'(i_m)) && (32'(c0) + 32'd1 >= 32'(i_m));
        lir  = (32'(c0) + 32'd1 == 32'(i_fw));
        lif  = lir && (32'(r0) + 32'd1 == 32'(i_fh));
        nc = c0 + 1'b1;
        nr = r0;
        ns = s0;
        if (nc >= i_fw) begin
            nc = '0;
            nr = r0 + 12'd1;
            ns = (s0 == SW'(ROWS-1)) ? '0 : s0 + 1'b1;
            if (nr >= i_fh) begin
                nr = '0;
                ns = '0;
            end
        end
    end

    for (genvar s = 0; s < ROWS; s++) begin : g_slot
        logic [7:0] mem [MAX_WIDTH];
        logic [7:0] r_q;
        always_ff @(posedge i_clk) begin
            if (accept) begin
                if (s0 == SW'(s)) mem[c0[CW-1:0]] <= i_item.pixel;
                r_q <= mem[c0[CW-1:0]];
            end
        end
        assign w_rd[s*8 +: 8] = r_q;
    end

    // New right-hand column: older rows from the line stores, newest at the bottom.
    always_comb begin
        int unsigned sl;
        sl = 0;
        w_col_in[WIN-1] = r_pix;
        for (int unsigned d = 1; d <= ROWS; d++) begin
            sl = 32'(r_cur_slot) + ROWS - d;
            if (sl >= ROWS) sl = sl - ROWS;
            w_col_in[WIN-1-d] = w_rd[sl[SW-1:0]*8 +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_col  <= nc[CW-1:0];
                r_row  <= nr[10:0];
                r_slot <= ns;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix      <= i_item.pixel;
            r_cur_slot <= s0;
            r_emit     <= emit;
            r_lir      <= lir;
            r_lif      <= lif;
        end
        if (r_state == F_SHIFT) begin
            for (int unsigned r = 0; r < WIN; r++) begin
                for (int unsigned c = 0; c < WIN; c++) begin
                    if (c == WIN - 1) r_win[r*WIN+c] <= w_col_in[r];
                    else              r_win[r*WIN+c] <= r_win[r*WIN+c+1];
                end
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_push = 1'b0;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_SHIFT;
            F_SHIFT: n_state = r_emit ? F_PUSH : F_IDLE;
            F_PUSH: begin
                o_q_push = !i_q_full;
                if (!i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        for (int unsigned i = 0; i < CELLS; i++) o_q_win[i*8 +: 8] = r_win[i];
        o_q_meta.size          = i_m;
        o_q_meta.last_in_row   = r_lir;
        o_q_meta.last_in_frame = r_lif;
        o_q_meta.centre        = r_win[(WIN-2)*(WIN+1)];
        for (int unsigned rad = 1; rad <= (WIN-1)/2; rad++) begin
            if (i_m == 4'(2*rad+1)) o_q_meta.centre = r_win[(WIN-1-rad)*(WIN+1)];
        end
    end
endmodule

@@ sv/amf_back.sv @@
// Back: per-size min, max and median by a bitwise rank search over a rotating window.
module amf_back #(
    parameter int unsigned MAX_WINDOW = amf_pkg::MAX_WINDOW_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    input  logic [(((MAX_WINDOW-1)/2)*2+1)**2*8-1:0] i_q_win,
    input  amf_pkg::t_meta i_q_meta,
    output logic           o_empty,
    input  logic           i_pop,
    output amf_pkg::t_out  o_item
);
    import amf_pkg::*;

    localparam int unsigned WIN   = ((MAX_WINDOW - 1) / 2) * 2 + 1;
    localparam int unsigned CELLS = WIN * WIN;
    localparam int unsigned IW    = $clog2(WIN);
    localparam int unsigned CNTW  = $clog2(CELLS + 1);

    t_bstate r_state, n_state;
    logic [7:0]      r_ring [CELLS];
    logic [3:0]      r_m, r_k;
    logic [2:0]      r_bit;
    logic [IW-1:0]   r_pr, r_pc;
    logic [CNTW-1:0] r_cnt;
    logic [7:0]      r_cand, r_lo, r_hi, r_centre, r_res;
    logic            r_lir, r_lif, r_kept;
    logic [2:0]      r_used;
    logic            r_out_valid;
    t_out            r_out;

    logic [3:0]      rad, cy, kr, lo_b, hi_b;
    logic            inreg, inc, end_pass, le, found, keep;
    logic [7:0]      head, t, cand_n, lo_n, hi_n, kidx;
    logic [CNTW-1:0] cnt_n;

    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty;
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;
    assign head    = r_ring[0];

    always_comb begin
        rad      = (r_m - 4'd1) >> 1;
        cy       = 4'(WIN - 1) - rad;
        kr       = (r_k - 4'd1) >> 1;
        lo_b     = cy - kr;
        hi_b     = cy + kr;
        inreg    = (4'(r_pr) >= lo_b) && (4'(r_pr) <= hi_b) &&
                   (4'(r_pc) >= lo_b) && (4'(r_pc) <= hi_b);
        t        = r_cand | (8'd1 << r_bit);
        inc      = inreg && (head < t);
        cnt_n    = r_cnt + CNTW'(inc);
        kidx     = (8'(r_k) * 8'(r_k)) >> 1;
        le       = (8'(cnt_n) <= kidx);
        cand_n   = le ? t : r_cand;
        lo_n     = (r_bit == 3'd7 && inreg && head < r_lo) ? head : r_lo;
        hi_n     = (r_bit == 3'd7 && inreg && head > r_hi) ? head : r_hi;
        end_pass = (r_pr == IW'(WIN-1)) && (r_pc == IW'(WIN-1));
        found    = (r_lo < cand_n) && (cand_n < r_hi);
        keep     = (r_lo < r_centre) && (r_centre < r_hi);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_SCAN;
            B_SCAN: if (end_pass && r_bit == 3'd0 && (found || r_k >= r_m)) n_state = B_DONE;
            B_DONE: if (!r_out_valid || i_pop) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DONE && (!r_out_valid || i_pop)) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_q_pop) begin
                    for (int unsigned i = 0; i < CELLS; i++) r_ring[i] <= i_q_win[i*8 +: 8];
                    r_m      <= i_q_meta.size;
                    r_centre <= i_q_meta.centre;
                    r_lir    <= i_q_meta.last_in_row;
                    r_lif    <= i_q_meta.last_in_frame;
                    r_k      <= 4'd3;
                    r_bit    <= 3'd7;
                    r_pr     <= '0;
                    r_pc     <= '0;
                    r_cnt    <= '0;
                    r_cand   <= '0;
                    r_lo     <= 8'hFF;
                    r_hi     <= 8'h00;
                end
            end
            B_SCAN: begin
                // Rotate so every cell passes the head once per pass.
                for (int unsigned i = 0; i < CELLS - 1; i++) r_ring[i] <= r_ring[i+1];
                r_ring[CELLS-1] <= r_ring[0];
                if (r_pc == IW'(WIN-1)) begin
                    r_pc <= '0;
                    r_pr <= (r_pr == IW'(WIN-1)) ? '0 : r_pr + 1'b1;
                end else begin
                    r_pc <= r_pc + 1'b1;
                end
                if (!end_pass) begin
                    r_cnt <= cnt_n;
                    r_lo  <= lo_n;
                    r_hi  <= hi_n;
                end else if (r_bit != 3'd0) begin
                    r_bit  <= r_bit - 3'd1;
                    r_cnt  <= '0;
                    r_cand <= cand_n;
                    r_lo   <= lo_n;
                    r_hi   <= hi_n;
                end else if (found) begin
                    r_res  <= keep ? r_centre : cand_n;
                    r_kept <= keep;
                    r_used <= r_k[2:0];
                end else if (r_k >= r_m) begin
                    r_res  <= cand_n;
                    r_kept <= 1'b0;
                    r_used <= r_m[2:0];
                end else begin
                    // Grow the window and restart the search.
                    r_k    <= r_k + 4'd2;
                    r_bit  <= 3'd7;
                    r_cnt  <= '0;
                    r_cand <= '0;
                    r_lo   <= 8'hFF;
                    r_hi   <= 8'h00;
                end
            end
            default: ;
        endcase
        if (r_state == B_DONE && (!r_out_valid || i_pop)) begin
            r_out.filtered_pixel <= r_res;
            r_out.window_used    <= r_used;
            r_out.kept_original  <= r_kept;
            r_out.last_in_row    <= r_lir;
            r_out.last_in_frame  <= r_lif;
        end
    end

    a_size_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_SCAN |-> (r_k[0] && r_k <= r_m && r_k >= 4'd3))
        else $error("window size out of range during scan");
endmodule

@@ sv/adaptive_median_filter_core.sv @@
// Top level of the adaptive median filter: config registers, front, queue and back.
// Front: each input pixel takes a line-store read, then a window shift, then, when a
// window is complete, a push that waits while the queue is full. Back: 8 rank passes
// over every cell of the largest window per tried size, then a result stage.
// The back's one-cell-per-cycle rank search sets the sustained rate while the output is popped.
// Synchronous active-low reset clears counters, state machines, queue and config.
module adaptive_median_filter_core #(
    parameter int unsigned MAX_WINDOW = amf_pkg::MAX_WINDOW_DEF,
    parameter int unsigned MAX_WIDTH  = amf_pkg::MAX_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  amf_pkg::t_in         i_item,
    output logic                 empty,
    input  logic                 pop,
    output amf_pkg::t_out        o_item,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_index,
    input  logic [amf_pkg::CFG_W-1:0] i_cfg_data
);
    import amf_pkg::*;

    localparam int unsigned WIN   = ((MAX_WINDOW - 1) / 2) * 2 + 1;
    localparam int unsigned CELLS = WIN * WIN;
    localparam int unsigned CW    = $clog2(MAX_WIDTH);

    logic [CFG_W-1:0] r_fw, r_fh;
    logic [2:0]       r_mw;

    logic [CW:0]      fw;
    logic [11:0]      fh;
    logic [3:0]       m;

    logic             q_push, q_full, q_empty, q_pop;
    logic [CELLS*8+$bits(t_meta)-1:0] q_in, q_out;
    logic [CELLS*8-1:0] f_win;
    t_meta            f_meta;

    // Register writes: hold the value until the next write to the same index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FRAME_WIDTH_RST;
            r_fh <= FRAME_HEIGHT_RST;
            r_mw <= MAX_WINDOW_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                CFG_MAX_WINDOW:   r_mw <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Clamp width and height: zero acts as one, oversize saturates.
    always_comb begin
        if (r_fw == '0)                     fw = (CW+1)'(1);
        else if (32'(r_fw) > MAX_WIDTH)     fw = (CW+1)'(MAX_WIDTH);
        else                                fw = (CW+1)'(r_fw);
        if (r_fh == '0)                     fh = 12'd1;
        else if (32'(r_fh) > HEIGHT_CAP)    fh = 12'(HEIGHT_CAP);
        else                                fh = r_fh;
        m = eff_size(r_mw, 4'(WIN));
    end

    amf_front #(.MAX_WINDOW(MAX_WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_fw     (fw),
        .i_fh     (fh),
        .i_m      (m),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_q_win  (f_win),
        .o_q_meta (f_meta)
    );

    assign q_in = {f_win, f_meta};

    // Decouple classification from the slow filtering work.
    amf_queue #(.DW(CELLS*8+$bits(t_meta))) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_data  (q_in),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    amf_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_q_win   (q_out[CELLS*8+$bits(t_meta)-1 -: CELLS*8]),
        .i_q_meta  (t_meta'(q_out[$bits(t_meta)-1:0])),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );
endmodule

@@ dv/adaptive_median_filter_core_test.sv @@
// Self-checking testbench for the adaptive median filter core.
module adaptive_median_filter_core_test;
    import amf_pkg::*;

    localparam int unsigned CAP       = 7;            // largest window the core is built for
    localparam int unsigned LINES     = CAP - 1;      // rows held in the line memory
    localparam int unsigned WIDTH_MAX = 2048;
    localparam int unsigned SETTLE    = 1500;         // worst-case back-end time for one window
    localparam int unsigned ITEM_GOAL = 750;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in         i_item;
    logic        empty;
    logic        pop;
    t_out        o_item;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    adaptive_median_filter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: shadow registers, line memory, window columns, counters.
    logic [11:0] width_reg  = FRAME_WIDTH_RST;
    logic [11:0] height_reg = FRAME_HEIGHT_RST;
    logic [2:0]  window_reg = MAX_WINDOW_RST;
    logic [7:0]  line_mem [LINES][WIDTH_MAX];
    logic [7:0]  win_cols [CAP][CAP];
    int unsigned col_cnt = 0;
    int unsigned row_cnt = 0;

    t_in  pending_pixels[$];
    t_out filtered_q[$];
    int   err_count    = 0;
    int   items_queued = 0;
    bit   take_front   = 0;
    bit   hold_sender  = 0;
    int   gap_left     = 0;
    int   burst_left   = 0;
    int   stall_left   = 0;
    int   calm_left    = 0;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        err_count++;
    endtask

    // Apply one accepted pixel to the predictor; push a result if the window is complete.
    task automatic filter_pixel(input t_in px);
        int unsigned fw, fh, m, col, row, rs, slot, rad, cy, n, k, kr, used;
        logic [7:0]  vals[$];
        logic [7:0]  centre, med, lo, hi, res;
        bit          found, kept;
        t_out        y;
        fw = (width_reg == 0) ? 1 : ((width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg);
        fh = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg);
        m = window_reg;
        if (m[0] == 1'b0 && m > 0) m--;
        if (m < 3) m = 3;
        if (m > CAP) m = CAP;

        if (px.first_of_frame) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= fw) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= fh) row_cnt = 0;
        col = col_cnt;
        row = row_cnt;

        // Advance the window one column, refill the newest column from the line memory.
        for (int r = 0; r < CAP; r++)
            for (int c = 0; c < CAP - 1; c++) win_cols[r][c] = win_cols[r][c+1];
        rs = row % LINES;
        for (int d = 1; d <= LINES; d++) begin
            slot = (rs + LINES - d) % LINES;
            win_cols[CAP-1-d][CAP-1] = line_mem[slot][col];
        end
        win_cols[CAP-1][CAP-1] = px.pixel;
        line_mem[rs][col] = px.pixel;

        if (row + 1 >= m && col + 1 >= m) begin
            rad = (m - 1) / 2;
            cy = CAP - 1 - rad;
            centre = win_cols[cy][cy];
            found = 0;
            kept = 0;
            used = m;
            res = 0;
            med = 0;
            for (k = 3; k <= m && !found; k += 2) begin
                kr = (k - 1) / 2;
                vals.delete();
                for (int r = cy - kr; r <= cy + kr; r++)
                    for (int c = cy - kr; c <= cy + kr; c++) vals.push_back(win_cols[r][c]);
                vals.sort();
                n = vals.size();
                lo = vals[0];
                hi = vals[n-1];
                med = vals[n/2];
                if (lo < med && med < hi) begin
                    found = 1;
                    used = k;
                    if (lo < centre && centre < hi) begin
                        res = centre;
                        kept = 1;
                    end else begin
                        res = med;
                    end
                end
            end
            if (!found) res = med;
            y.filtered_pixel = res;
            y.window_used    = used[2:0];
            y.kept_original  = kept;
            y.last_in_row    = (col == fw - 1);
            y.last_in_frame  = (col == fw - 1) && (row == fh - 1);
            filtered_q.push_back(y);
        end

        col_cnt = col + 1;
        if (col_cnt >= fw) begin
            col_cnt = 0;
            row_cnt = row + 1;
            if (row_cnt >= fh) row_cnt = 0;
        end
    endtask

    // Input side: record each transfer at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            filter_pixel(i_item);
            take_front = 1;
        end
    end

    // Sender: drop the transferred pixel, then drive the next one in bursts with gaps.
    always @(negedge i_clk) begin
        bit   nxt_push;
        t_in  nxt_item;
        nxt_item = i_item;
        if (take_front) begin
            void'(pending_pixels.pop_front());
            take_front = 0;
        end
        nxt_push = 1'b0;
        if (i_rst_n && !hold_sender && pending_pixels.size() > 0) begin
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                nxt_push = 1'b1;
                nxt_item = pending_pixels[0];
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // Long bursts sometimes, so the front end also runs back to back.
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                            : $urandom_range(0, 6);
                    gap_left   = $urandom_range(0, 5);
                end
            end
        end
        push   <= nxt_push;
        i_item <= nxt_item;
    end

    // Receiver: stall in random bursts, with calm stretches that never stall.
    always @(negedge i_clk) begin
        bit nxt_pop;
        nxt_pop = 1'b1;
        if (calm_left > 0) begin
            calm_left--;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt_pop = 1'b0;
        end else begin
            case ($urandom_range(0, 15))
                0:       calm_left  = $urandom_range(200, 2000);
                1, 2, 3: stall_left = $urandom_range(1, 25);
                default: ;
            endcase
        end
        pop <= nxt_pop;
    end

    // Output side: check each transfer against the oldest expected result.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && pop && !empty) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("unexpected result, pixel", o_item.filtered_pixel, -1);
            end else begin
                want = filtered_q.pop_front();
                if (o_item.filtered_pixel !== want.filtered_pixel)
                    report_mismatch("filtered_pixel", o_item.filtered_pixel, want.filtered_pixel);
                if (o_item.window_used !== want.window_used)
                    report_mismatch("window_used", o_item.window_used, want.window_used);
                if (o_item.kept_original !== want.kept_original)
                    report_mismatch("kept_original", o_item.kept_original, want.kept_original);
                if (o_item.last_in_row !== want.last_in_row)
                    report_mismatch("last_in_row", o_item.last_in_row, want.last_in_row);
                if (o_item.last_in_frame !== want.last_in_frame)
                    report_mismatch("last_in_frame", o_item.last_in_frame, want.last_in_frame);
            end
        end
    end

    // Wait until every pixel is transferred and every result drained, then let the back settle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_pixels.size() != 0 || push || filtered_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register while the core is idle and mirror it in the predictor.
    task automatic write_reg(input t_cfg_idx idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_FRAME_WIDTH:  width_reg  = val;
            CFG_FRAME_HEIGHT: height_reg = val;
            CFG_MAX_WINDOW:   window_reg = val[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic add_pixel(input logic [7:0] level, input bit mark);
        t_in px;
        px.pixel          = level;
        px.first_of_frame = mark;
        pending_pixels.push_back(px);
        items_queued++;
    endtask

    // Level per style: uniform noise, smooth texture with impulse noise, or four coarse levels.
    function automatic logic [7:0] pick_level(input int style, input logic [7:0] base);
        int v;
        case (style)
            0: return 8'($urandom);
            1: begin
                if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
                v = int'(base) + $urandom_range(0, 8) - 4;
                return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
            end
            default: return 8'($urandom_range(0, 3) * 85);
        endcase
    endfunction

    // Queue count pixels of one frame; the first carries the frame mark when asked.
    task automatic add_frame(input int count, input bit mark, input int style);
        logic [7:0] base;
        base = 8'($urandom_range(20, 235));
        for (int i = 0; i < count; i++) add_pixel(pick_level(style, base), mark && (i == 0));
    endtask

    initial begin
        int w, h, mw, nfr, cnt;
        bit held;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_item      = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 7x7 frame at the largest window; one output from a field of 0x55 and 0xAA
        // with impulses at both extremes, with every pixel bit toggled along the way.
        write_reg(CFG_FRAME_WIDTH, 12'd7);
        write_reg(CFG_FRAME_HEIGHT, 12'd7);
        write_reg(CFG_MAX_WINDOW, 3'd7);
        for (int i = 0; i < 49; i++)
            add_pixel((i == 24) ? 8'hFF : ((i % 7 == 0) ? 8'h00 :
                      ((i % 5 == 0) ? 8'hAA : 8'h55)), i == 0);
        drain();

        // Directed: even and undersized window settings on a small frame.
        write_reg(CFG_MAX_WINDOW, 3'd0);
        add_frame(49, 1, 1);
        drain();
        write_reg(CFG_MAX_WINDOW, 3'd6);
        add_frame(49, 1, 2);
        drain();

        // Zero and oversize width and height: frames too narrow, too wide or too short to emit anything.
        write_reg(CFG_FRAME_WIDTH, 12'd0);
        add_frame(10, 1, 0);
        drain();
        write_reg(CFG_FRAME_WIDTH, 12'hFFF);
        write_reg(CFG_FRAME_HEIGHT, 12'd0);
        add_frame(10, 1, 0);
        drain();
        write_reg(CFG_FRAME_HEIGHT, 12'hFFF);
        write_reg(CFG_FRAME_WIDTH, 12'd5);
        add_frame(12, 1, 0);
        drain();

        // Width shrinks under a running count: the next pixel starts a new row.
        write_reg(CFG_FRAME_WIDTH, 12'd12);
        write_reg(CFG_FRAME_HEIGHT, 12'd10);
        write_reg(CFG_MAX_WINDOW, 3'd5);
        add_frame(12 * 2 + 11, 1, 1);
        drain();
        write_reg(CFG_FRAME_WIDTH, 12'd8);
        add_frame(8 * 8, 0, 1);
        drain();

        // Height shrinks while a frame is running, then the frame wraps with no mark.
        write_reg(CFG_FRAME_HEIGHT, 12'd7);
        add_frame(8 * 7 * 2, 0, 1);
        drain();

        // Random part: marked frames with random content; some cut short. Every frame
        // carries the mark so no window reaches line-store columns left unwritten.
        held = 0;
        while (items_queued < ITEM_GOAL) begin
            w   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(7, 12);
            h   = $urandom_range(7, 9);
            mw  = $urandom_range(0, 7);
            nfr = $urandom_range(1, 2);
            write_reg(CFG_FRAME_WIDTH, 12'(w));
            write_reg(CFG_FRAME_HEIGHT, 12'(h));
            write_reg(CFG_MAX_WINDOW, 3'(mw));
            for (int f = 0; f < nfr; f++) begin
                cnt = w * h;
                if ($urandom_range(0, 5) == 0) cnt = $urandom_range(1, cnt);
                add_frame(cnt, 1'b1, $urandom_range(0, 2));
            end
            // Hold the sender once until the core has delivered everything it owes.
            if (!held && items_queued > ITEM_GOAL / 2) begin
                held = 1;
                wait (pending_pixels.size() < w * h / 2);
                @(negedge i_clk);
                hold_sender = 1;
                do @(posedge i_clk);
                while (filtered_q.size() != 0);
                @(negedge i_clk);
                hold_sender = 0;
            end
            drain();
        end

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
